@@ rtl/fifo_tiebreak_priority_queue_macros.svh @@
// ----------------------------------------------------------------------------
// fifo_tiebreak_priority_queue_macros
// assertion macros shared by the priority queue rtl
// ----------------------------------------------------------------------------
`ifndef FIFO_TIEBREAK_PRIORITY_QUEUE_MACROS_SVH
`define FIFO_TIEBREAK_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define FTPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define FTPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ftpq_pkg.sv @@
// ----------------------------------------------------------------------------
// ftpq_pkg
// shared types and constants of the priority queue
// ----------------------------------------------------------------------------
package ftpq_pkg;

    localparam int IN_TAG_W    = 16;
    localparam int IN_PRI_W    = 32;
    localparam int MODE_W      = 2;
    localparam int OUT_TAG_W   = 16;
    localparam int STATUS_W    = 2;
    localparam int OUT_CNT_W   = 5;
    localparam int ORDER_W     = 32;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_EXTRACT = 2'd1,
        MODE_PEEK    = 2'd2,
        MODE_MODIFY  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic scan;
        logic commit;
    } ftpq_cmd_t;

    typedef struct packed {
        logic addr_last;
        logic out_free;
    } ftpq_sts_t;

endpackage

@@ rtl/ftpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// ftpq_ctrl
// sequencer: clearing pass, request load, table scan and commit
// ----------------------------------------------------------------------------
`include "fifo_tiebreak_priority_queue_macros.svh"

module ftpq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ftpq_pkg::ftpq_sts_t sts,
    output ftpq_pkg::ftpq_cmd_t cmd
);
    import ftpq_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                    ready_next = 1'b0;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.addr_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_CLEAR;
                ready_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_tready = ready_reg;

    `FTPQ_ASSERT_IMP(a_commit_free, aclk, aresetn, cmd.commit, sts.out_free, "commit blocked")
    `FTPQ_ASSERT_NXT(a_start_scan, aclk, aresetn, cmd.start, cmd.scan, "scan not started")
    `FTPQ_ASSERT_NXT(a_scan_drain, aclk, aresetn, cmd.scan && sts.addr_last,
                     state_reg == ST_DRAIN, "scan end missed")
    `FTPQ_ASSERT_IMP(a_ready_idle, aclk, aresetn, cmd.scan || cmd.clear, !s_tready,
                     "ready while busy")

endmodule

@@ rtl/ftpq_dp.sv @@
// ----------------------------------------------------------------------------
// ftpq_dp
// entry memory, scan compare, commit update and result register
// ----------------------------------------------------------------------------
`include "fifo_tiebreak_priority_queue_macros.svh"

module ftpq_dp #(
    parameter int CAPACITY      = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ftpq_pkg::ftpq_cmd_t                 cmd,
    output ftpq_pkg::ftpq_sts_t                 sts,
    input  logic [ftpq_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [ftpq_pkg::MODE_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ftpq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [ftpq_pkg::STATUS_W-1:0]       m_tuser
);
    import ftpq_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int EW    = 1 + TAG_BITS + PRIORITY_BITS + ORDER_W;
    localparam int O_LO  = 0;
    localparam int P_LO  = ORDER_W;
    localparam int T_LO  = ORDER_W + PRIORITY_BITS;
    localparam int V_BIT = EW - 1;

    logic [EW-1:0]            mem [CAPACITY];
    logic [EW-1:0]            rd_reg;
    logic [AW-1:0]            addr_reg;
    logic                     ev_vld_reg;
    logic [AW-1:0]            ev_idx_reg;

    mode_t                    req_mode_reg;
    logic [TAG_BITS-1:0]      req_tag_reg;
    logic [PRIORITY_BITS-1:0] req_pri_reg;

    logic                     best_found_reg;
    logic [AW-1:0]            best_idx_reg;
    logic [TAG_BITS-1:0]      best_tag_reg;
    logic [PRIORITY_BITS-1:0] best_pri_reg;
    logic [ORDER_W-1:0]       best_order_reg;
    logic [ORDER_W-1:0]       best_age_reg;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ORDER_W-1:0]       counter_reg, counter_next;

    logic                     m_valid_reg;
    logic [OUT_TAG_W-1:0]     m_tag_reg;
    status_t                  m_status_reg;
    logic [OUT_CNT_W-1:0]     m_count_reg;

    // scan compare
    logic                     rd_valid;
    logic [TAG_BITS-1:0]      rd_tag;
    logic [PRIORITY_BITS-1:0] rd_pri;
    logic [ORDER_W-1:0]       rd_order;
    logic [ORDER_W-1:0]       rd_age;
    logic                     cand;

    // commit
    logic                     cm_we;
    logic [EW-1:0]            cm_wdata;
    status_t                  cm_status;
    logic [OUT_TAG_W-1:0]     cm_tag;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [EW-1:0]            wdata;

    assign rd_valid = rd_reg[V_BIT];
    assign rd_tag   = rd_reg[T_LO +: TAG_BITS];
    assign rd_pri   = rd_reg[P_LO +: PRIORITY_BITS];
    assign rd_order = rd_reg[O_LO +: ORDER_W];
    assign rd_age   = counter_reg - rd_order;

    always_comb begin
        cand = 1'b0;
        case (req_mode_reg)
            MODE_INSERT: cand = !rd_valid && !best_found_reg;
            MODE_EXTRACT, MODE_PEEK: begin
                cand = rd_valid && (!best_found_reg
                       || ($signed(rd_pri) > $signed(best_pri_reg))
                       || ((rd_pri == best_pri_reg) && (rd_age > best_age_reg)));
            end
            MODE_MODIFY: begin
                cand = rd_valid && (rd_tag == req_tag_reg)
                       && (!best_found_reg || (rd_age > best_age_reg));
            end
            default: cand = 1'b0;
        endcase
    end

    always_comb begin
        cm_we        = 1'b0;
        cm_wdata     = {1'b0, best_tag_reg, best_pri_reg, best_order_reg};
        cm_status    = STAT_OK;
        cm_tag       = '0;
        count_next   = count_reg;
        counter_next = counter_reg;
        case (req_mode_reg)
            MODE_INSERT: begin
                if (best_found_reg) begin
                    cm_we        = 1'b1;
                    cm_wdata     = {1'b1, req_tag_reg, req_pri_reg, counter_reg};
                    count_next   = count_reg + 1'b1;
                    counter_next = counter_reg + 1'b1;
                end else begin
                    cm_status = STAT_FULL;
                end
            end
            MODE_EXTRACT, MODE_PEEK: begin
                if (best_found_reg) begin
                    cm_tag = OUT_TAG_W'(best_tag_reg);
                    if (req_mode_reg == MODE_EXTRACT) begin
                        cm_we      = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end else begin
                    cm_status = STAT_EMPTY;
                end
            end
            MODE_MODIFY: begin
                if (best_found_reg) begin
                    cm_we    = 1'b1;
                    cm_wdata = {1'b1, best_tag_reg, req_pri_reg, best_order_reg};
                end else begin
                    cm_status = STAT_NOT_FOUND;
                end
            end
            default: cm_status = STAT_OK;
        endcase
    end

    assign we    = cmd.clear || (cmd.commit && cm_we);
    assign waddr = cmd.clear ? addr_reg : best_idx_reg;
    assign wdata = cmd.clear ? '0 : cm_wdata;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.scan) begin
            rd_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg    <= '0;
            ev_vld_reg  <= 1'b0;
            count_reg   <= '0;
            counter_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            ev_vld_reg <= cmd.scan;
            if (cmd.start) begin
                addr_reg <= '0;
            end else if (cmd.clear || cmd.scan) begin
                addr_reg <= sts.addr_last ? '0 : addr_reg + 1'b1;
            end
            if (cmd.commit) begin
                count_reg   <= count_next;
                counter_reg <= counter_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ev_idx_reg <= addr_reg;
        if (cmd.start) begin
            req_mode_reg   <= mode_t'(s_tuser);
            req_tag_reg    <= TAG_BITS'(s_tdata[IN_TAG_W-1:0]);
            req_pri_reg    <= PRIORITY_BITS'(s_tdata[IN_TAG_W +: IN_PRI_W]);
            best_found_reg <= 1'b0;
        end else if (ev_vld_reg && cand) begin
            best_found_reg <= 1'b1;
            best_idx_reg   <= ev_idx_reg;
            best_tag_reg   <= rd_tag;
            best_pri_reg   <= rd_pri;
            best_order_reg <= rd_order;
            best_age_reg   <= rd_age;
        end
        if (cmd.commit) begin
            m_tag_reg    <= cm_tag;
            m_status_reg <= cm_status;
            m_count_reg  <= OUT_CNT_W'(count_next);
        end
    end

    assign sts.addr_last = (addr_reg == AW'(CAPACITY - 1));
    assign sts.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_TAG_W - OUT_CNT_W){1'b0}}, m_count_reg, m_tag_reg};
    assign m_tuser  = m_status_reg;

    `FTPQ_ASSERT_IMP(a_count_max, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY),
                     "count overflow")
    `FTPQ_ASSERT_NXT(a_full_count, aclk, aresetn,
                     cmd.commit && (req_mode_reg == MODE_INSERT) && !best_found_reg,
                     count_reg == CNT_W'(CAPACITY), "full with free slot")
    `FTPQ_ASSERT_IMP(a_valid_src, aclk, aresetn, $rose(m_valid_reg), $past(cmd.commit),
                     "result without commit")

endmodule

@@ rtl/fifo_tiebreak_priority_queue.sv @@
// ----------------------------------------------------------------------------
// fifo_tiebreak_priority_queue
// bounded max-priority queue over an unsorted entry table, ties to oldest
// ----------------------------------------------------------------------------
//  channel  dir  tdata                           tuser
//  s_       in   [15:0] value_tag,               [1:0] mode
//                [47:16] priority_req
//  m_       out  [15:0] result_tag,              [1:0] status
//                [20:16] count
//
//  from accept to result valid each word runs a scan that reads the entry
//  memory once per slot, a drain for the last compare and a commit; no new
//  word is taken until the previous one has committed
//  after reset a clearing pass over every slot runs with s_tready low
//  a new word is taken while the previous result waits; its commit stalls
//  until that result is taken
// ----------------------------------------------------------------------------
module fifo_tiebreak_priority_queue #(
    parameter int CAPACITY      = 16,
    parameter int TAG_BITS      = 16,
    parameter int PRIORITY_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ftpq_pkg::S_TDATA_W-1:0] s_tdata,   // value_tag, priority_req
    input  logic [ftpq_pkg::MODE_W-1:0]    s_tuser,   // mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ftpq_pkg::M_TDATA_W-1:0] m_tdata,   // result_tag, count
    output logic [ftpq_pkg::STATUS_W-1:0]  m_tuser    // status
);
    import ftpq_pkg::*;

    ftpq_cmd_t cmd;
    ftpq_sts_t sts;

    ftpq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ftpq_dp #(
        .CAPACITY      (CAPACITY),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
